/* design/plti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// shared widths, status codes and the scan token of the interpolation table
// ----------------------------------------------------------------------------
package plti_pkg;

	// field widths
	localparam int W       = 48;
	localparam int SEG_W   = 5;
	localparam int ST_W    = 3;
	localparam int IDX_W   = 5;
	localparam int CNT_W   = 6;

	// fraction bits of a value word, sets the above-range result
	localparam int VALUE_FRAC_BITS = 32;

	// stream packing
	localparam int S_TDATA_W  = 152;
	localparam int IN_IDX_LSB = 0;
	localparam int IN_DOM_LSB = IN_IDX_LSB + IDX_W;
	localparam int IN_VAL_LSB = IN_DOM_LSB + W;
	localparam int IN_QRY_LSB = IN_VAL_LSB + W;
	localparam int M_TDATA_W  = 56;
	localparam int OUT_SEG_LSB = W;

	// request kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// result status codes
	localparam logic [ST_W-1:0] STAT_EXACT  = 3'd0;
	localparam logic [ST_W-1:0] STAT_INTERP = 3'd1;
	localparam logic [ST_W-1:0] STAT_BELOW  = 3'd2;
	localparam logic [ST_W-1:0] STAT_ABOVE  = 3'd3;
	localparam logic [ST_W-1:0] STAT_LOAD   = 3'd4;

	// -1.0 in value fixed point
	localparam logic [W-1:0] ABOVE_VALUE = {W{1'b1}} << VALUE_FRAC_BITS;

	// token that walks the cell chain
	typedef struct packed {
		logic            done;
		logic [ST_W-1:0] status;
		logic [SEG_W-1:0] seg;
		logic [W-1:0]    q;
		logic [W-1:0]    d0;
		logic [W-1:0]    r0;
		logic [W-1:0]    d1;
		logic [W-1:0]    r1;
	} plti_tok_t;

endpackage

/* design/plti_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_cell
// one breakpoint entry plus one stage of the scan token chain
// ----------------------------------------------------------------------------
module plti_cell import plti_pkg::*; #(
	parameter int CELL_INDEX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      active,
	input  logic      wr_en,
	input  logic [W-1:0] wr_domain,
	input  logic [W-1:0] wr_value,
	input  logic      in_valid,
	input  plti_tok_t in_tok,
	output logic      out_valid,
	output plti_tok_t out_tok
);

	localparam logic [SEG_W-1:0] SEG = SEG_W'(CELL_INDEX);

	logic [W-1:0] domain_q;
	logic [W-1:0] value_q;
	plti_tok_t    nxt;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			domain_q <= wr_domain;
			value_q  <= wr_value;
		end
	end

	always_comb begin
		nxt = in_tok;
		if (active && !in_tok.done) begin
			if (domain_q == in_tok.q) begin
				nxt.done   = 1'b1;
				nxt.status = STAT_EXACT;
				nxt.seg    = SEG;
				nxt.r0     = value_q;
			end else if ($signed(in_tok.q) < $signed(domain_q)) begin
				nxt.done = 1'b1;
				if (CELL_INDEX == 0) begin
					nxt.status = STAT_BELOW;
					nxt.seg    = '0;
					nxt.r0     = value_q;
				end else begin
					// lower end stays in d0/r0 from the previous cell
					nxt.status = STAT_INTERP;
					nxt.seg    = SEG;
					nxt.d1     = domain_q;
					nxt.r1     = value_q;
				end
			end else begin
				nxt.d0 = domain_q;
				nxt.r0 = value_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			out_tok <= nxt;
		end
	end

endmodule

/* design/plti_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_muldiv
// mag * num / den, truncated; chunked multiply then restoring divide
// ----------------------------------------------------------------------------
module plti_muldiv import plti_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] mag,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int MUL_CHUNK = 16;
	localparam int MUL_STEPS = W / MUL_CHUNK;
	localparam int DIV_STEPS = W;
	localparam int PROD_W    = 2 * W;
	localparam int STEP_W    = 6;

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t             state_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [W-1:0]          mag_q;
	logic [W-1:0]          num_q;
	logic [W-1:0]          den_q;
	logic [PROD_W-1:0]     acc_q;
	logic                  done_q;
	logic [W+MUL_CHUNK-1:0] pp;
	logic [W:0]            trial;

	assign pp    = mag_q * num_q[W-1 -: MUL_CHUNK];
	// partial remainder with the next dividend bit against the divisor
	assign trial = acc_q[PROD_W-1 -: W+1] - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (start) begin
						state_q <= MD_MUL;
						cnt_q   <= '0;
					end
				end
				MD_MUL: begin
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						state_q <= MD_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				MD_DIV: begin
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= MD_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					mag_q <= mag;
					num_q <= num;
					den_q <= den;
					acc_q <= '0;
				end
			end
			MD_MUL: begin
				acc_q <= (acc_q << MUL_CHUNK) + PROD_W'(pp);
				num_q <= num_q << MUL_CHUNK;
			end
			MD_DIV: begin
				if (!trial[W]) begin
					acc_q <= {trial[W-1:0], acc_q[W-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[PROD_W-2:0], 1'b0};
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done = done_q;
	assign quo  = acc_q[W-1:0];

endmodule

/* design/piecewise_linear_table_interp_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top
// breakpoint table with linear interpolation between entries
// ----------------------------------------------------------------------------
// The table lives in a row of MAX_ENTRIES cells, one breakpoint per cell. A
// load request writes one cell and returns status "load done" via S_DONE and
// the output register. A query request sends a token down the whole cell
// row, one cell per cycle, so every query passes all MAX_ENTRIES cells
// whatever entry_count is; exact hits, below-range and above-range answers
// then go through S_DONE to the output register. An interpolated answer
// first goes through the multiply/divide unit (48x16 partial products, then
// one-bit restoring division). One request is in flight at a time; the next
// is taken as soon as the result has moved into the output register, even
// if the sink has not taken it yet. entry_count may only be written while no
// request is in flight; a count of zero acts as one and a count above
// MAX_ENTRIES acts as MAX_ENTRIES.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top import plti_pkg::*; #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: entry_count
	input  logic                 cfg_we,
	input  logic [CNT_W-1:0]     cfg_wdata,
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_index[4:0], entry_domain[52:5], entry_value[100:53],
	// query_point[148:101], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic                 s_tuser,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// result_value[47:0], segment_index[52:48], zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	// status
	output logic [ST_W-1:0]      m_tuser
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_PREP = 5'b00100,
		S_CALC = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] entry_count_q;

	// request fields
	logic             s_accept;
	logic [IDX_W-1:0] entry_index;
	logic [W-1:0]     entry_domain;
	logic [W-1:0]     entry_value;
	logic [W-1:0]     query_point;

	// cell chain
	logic [MAX_ENTRIES-1:0] cell_active;
	logic [MAX_ENTRIES-1:0] cell_wr;
	logic [MAX_ENTRIES-1:0] tok_valid;
	plti_tok_t              tok [MAX_ENTRIES];
	logic                   inj_valid;
	plti_tok_t              inj_tok;
	logic                   last_valid;
	plti_tok_t              last_tok;

	// interpolation operands
	plti_tok_t    tok_q;
	logic [W:0]   dr;
	logic [W:0]   dr_mag;
	logic         dr_neg;
	logic [W-1:0] md_num;
	logic [W-1:0] md_den;
	logic         md_start;
	logic         md_done;
	logic [W-1:0] md_quo;

	// finished result waiting for the output register
	logic [W-1:0]     res_value_q;
	logic [ST_W-1:0]  res_status_q;
	logic [SEG_W-1:0] res_seg_q;
	logic             out_free;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [ST_W-1:0]      m_tuser_q;

	assign s_tready     = (state_q == S_IDLE);
	assign s_accept     = s_tvalid && s_tready;
	assign entry_index  = s_tdata[IN_IDX_LSB +: IDX_W];
	assign entry_domain = s_tdata[IN_DOM_LSB +: W];
	assign entry_value  = s_tdata[IN_VAL_LSB +: W];
	assign query_point  = s_tdata[IN_QRY_LSB +: W];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// a fresh token for a query enters the first cell
	assign inj_valid = s_accept && (s_tuser == KIND_QUERY);

	always_comb begin
		inj_tok        = '0;
		inj_tok.done   = 1'b0;
		inj_tok.status = STAT_ABOVE;
		inj_tok.q      = query_point;
	end

	genvar g;
	generate
		for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
			// cell 0 always takes part; cells past the count pass the token through
			assign cell_active[g] = (g == 0) || (32'(g) < 32'(entry_count_q));
			// slots outside the row are never written
			assign cell_wr[g] = s_accept && (s_tuser == KIND_LOAD)
			                    && (32'(entry_index) == 32'(g));
			if (g == 0) begin : g_head
				plti_cell #(.CELL_INDEX(g)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.active    (cell_active[g]),
					.wr_en     (cell_wr[g]),
					.wr_domain (entry_domain),
					.wr_value  (entry_value),
					.in_valid  (inj_valid),
					.in_tok    (inj_tok),
					.out_valid (tok_valid[g]),
					.out_tok   (tok[g])
				);
			end else begin : g_body
				plti_cell #(.CELL_INDEX(g)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.active    (cell_active[g]),
					.wr_en     (cell_wr[g]),
					.wr_domain (entry_domain),
					.wr_value  (entry_value),
					.in_valid  (tok_valid[g-1]),
					.in_tok    (tok[g-1]),
					.out_valid (tok_valid[g]),
					.out_tok   (tok[g])
				);
			end
		end
	endgenerate

	assign last_valid = tok_valid[MAX_ENTRIES-1];
	assign last_tok   = tok[MAX_ENTRIES-1];

	// operand prep: bracket satisfies d0 < q < d1, so both differences are positive
	assign dr     = {tok_q.r1[W-1], tok_q.r1} - {tok_q.r0[W-1], tok_q.r0};
	assign dr_neg = dr[W];
	assign dr_mag = dr_neg ? (~dr + 1'b1) : dr;
	assign md_num = tok_q.q - tok_q.d0;
	assign md_den = tok_q.d1 - tok_q.d0;
	assign md_start = (state_q == S_PREP);

	plti_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.mag    (dr_mag[W-1:0]),
		.num    (md_num),
		.den    (md_den),
		.done   (md_done),
		.quo    (md_quo)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						state_q <= (s_tuser == KIND_QUERY) ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (last_valid) begin
						state_q <= (last_tok.done && last_tok.status == STAT_INTERP)
						           ? S_PREP : S_DONE;
					end
				end
				S_PREP: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (md_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_accept && s_tuser == KIND_LOAD) begin
					res_value_q  <= '0;
					res_status_q <= STAT_LOAD;
					res_seg_q    <= '0;
				end
			end
			S_SCAN: begin
				if (last_valid) begin
					tok_q <= last_tok;
					if (last_tok.done) begin
						res_value_q  <= last_tok.r0;
						res_status_q <= last_tok.status;
						res_seg_q    <= last_tok.seg;
					end else begin
						// ran past the last active entry
						res_value_q  <= ABOVE_VALUE;
						res_status_q <= STAT_ABOVE;
						res_seg_q    <= '0;
					end
				end
			end
			S_CALC: begin
				if (md_done) begin
					res_value_q  <= dr_neg ? (tok_q.r0 - md_quo) : (tok_q.r0 + md_quo);
					res_status_q <= STAT_INTERP;
					res_seg_q    <= tok_q.seg;
				end
			end
			default: begin
				res_value_q <= res_value_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= M_TDATA_W'({res_seg_q, res_value_q});
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// at most one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one token in the cell chain");

	// an accepted query lands in the first cell
	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tuser == KIND_QUERY) |=> tok_valid[0])
		else $error("query token did not enter the chain");

	// the divider only finishes while it is awaited
	a_md_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_CALC))
		else $error("divider finished outside the calc state");

	// a finished division yields an interpolated result
	a_calc_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC && md_done) |=> (res_status_q == STAT_INTERP))
		else $error("interpolation result carries wrong status");

	// no token travels while idle or finishing
	a_chain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> (tok_valid == '0))
		else $error("token in chain outside a scan");

endmodule

/* sim/tb_piecewise_linear_table_interp_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interp_top
// self-checking bench for the breakpoint table with linear interpolation
// ----------------------------------------------------------------------------
// Loads and queries go in on the request stream. The bench keeps its own copy
// of the breakpoint table and the active entry count, and predicts every
// result. Each result is checked against the oldest prediction. The run has
// these parts:
// - hand-picked corner cases
// - a long receiver hold-off that backs up the request side
// - sorted tables at many entry counts with hits, segments and out-of-range
//   points
// - unsorted tables with random loads and queries mixed in
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interp_top;
	import plti_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int CYCLE_LIMIT = 1000000;
	// long enough for the slowest query, an interpolation, plus some slack
	localparam int TAIL_CYCLES = TABLE_DEPTH + 80;
	localparam int HOLD_CYCLES = 400;
	localparam longint FIELD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint FIELD_MIN = -64'sh0000_8000_0000_0000;

	typedef struct packed {
		logic [W-1:0]     value;
		logic [ST_W-1:0]  status;
		logic [SEG_W-1:0] seg;
	} lookup_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CNT_W-1:0]     cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]      m_tuser;

	// bench copy of the breakpoint table and the count register
	longint           bp_domain [TABLE_DEPTH];
	longint           bp_value [TABLE_DEPTH];
	logic [CNT_W-1:0] entry_count_model = 1;

	lookup_result_t expected_lookups [$];

	int error_count = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int settings_used = 0;
	int status_seen [5] = '{0, 0, 0, 0, 0};

	// shared knobs between the stimulus and the receiver
	logic steady_flow = 1'b0;
	int   sink_hold_cycles = 0;

	piecewise_linear_table_interp_top #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// random helpers
	// ------------------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	function automatic logic [W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[W-1:0];
	endfunction

	function automatic logic [63:0] rand_below(input logic [63:0] span);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r % span;
	endfunction

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// zero counts as one entry, anything past the table depth as the depth
	function automatic int active_entries();
		if (entry_count_model == 0)
			return 1;
		if (entry_count_model > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(entry_count_model);
	endfunction

	// r0 + trunc((r1 - r0) * (q - d0) / (d1 - d0)), with d0 < q < d1
	function automatic logic [W-1:0] interp_value(input longint d0, input longint r0,
			input longint d1, input longint r1, input longint q);
		longint       dr;
		logic [63:0]  mag;
		logic [63:0]  run;
		logic [63:0]  rise_den;
		logic [127:0] prod;
		logic [127:0] quo;
		longint       step;
		dr = r1 - r0;
		mag = (dr < 0) ? -dr : dr;
		run = q - d0;
		rise_den = d1 - d0;
		prod = {64'd0, mag} * {64'd0, run};
		quo = prod / {64'd0, rise_den};
		step = longint'(quo[63:0]);
		return (dr < 0) ? W'(r0 - step) : W'(r0 + step);
	endfunction

	function automatic lookup_result_t predict_lookup(input logic kind,
			input logic [IDX_W-1:0] idx, input logic [W-1:0] dom, input logic [W-1:0] val,
			input logic [W-1:0] qry);
		lookup_result_t res;
		longint         q;
		int             n;
		int             i;
		logic           hit;
		res.value = '0;
		res.status = STAT_LOAD;
		res.seg = '0;
		if (kind == KIND_LOAD) begin
			bp_domain[idx] = $signed(dom);
			bp_value[idx] = $signed(val);
			return res;
		end
		q = $signed(qry);
		n = active_entries();
		res.value = ABOVE_VALUE;
		res.status = STAT_ABOVE;
		hit = 1'b0;
		// the first entry that matches the point or lies above it decides
		for (i = 0; i < n; i++) begin
			if (!hit && bp_domain[i] == q) begin
				res.value = W'(bp_value[i]);
				res.status = STAT_EXACT;
				res.seg = SEG_W'(i);
				hit = 1'b1;
			end else if (!hit && q < bp_domain[i]) begin
				if (i == 0) begin
					res.value = W'(bp_value[0]);
					res.status = STAT_BELOW;
				end else begin
					res.value = interp_value(bp_domain[i-1], bp_value[i-1], bp_domain[i],
						bp_value[i], q);
					res.status = STAT_INTERP;
					res.seg = SEG_W'(i);
				end
				hit = 1'b1;
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// offer one request, return at the edge where it is taken
	task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx,
			input logic [W-1:0] dom, input logic [W-1:0] val, input logic [W-1:0] qry);
		logic [S_TDATA_W-1:0] payload;
		int                   gap;
		payload = '0;
		payload[IN_IDX_LSB +: IDX_W] = idx;
		payload[IN_DOM_LSB +: W] = dom;
		payload[IN_VAL_LSB +: W] = val;
		payload[IN_QRY_LSB +: W] = qry;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= payload;
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_lookups.push_back(predict_lookup(kind, idx, dom, val, qry));
		if (kind == KIND_LOAD)
			loads_sent++;
		else
			queries_sent++;
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_until_idle();
		s_tvalid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [CNT_W-1:0] count);
		wait_until_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		entry_count_model = count;
		settings_used++;
	endtask

	// ascending domains from a random base, step size at one of three scales
	task automatic load_sorted_table(input int n);
		longint step_max;
		longint base;
		longint d;
		int     i;
		case ($urandom_range(2))
			0: step_max = 256;
			1: step_max = 64'sd1 <<< 30;
			default: step_max = 64'sd1 <<< 42;
		endcase
		base = $signed(rand48());
		if ($urandom_range(7) == 0)
			base = FIELD_MIN;
		if (base > FIELD_MAX - n * step_max)
			base = FIELD_MAX - n * step_max;
		d = base;
		for (i = 0; i < n; i++) begin
			send_request(KIND_LOAD, IDX_W'(i), W'(d), rand48(), rand48());
			// an occasional repeated domain
			if ($urandom_range(15) != 0)
				d = d + 1 + longint'(rand_below(step_max));
		end
	endtask

	// a point that hits, falls in a segment, or lands outside the sorted table
	function automatic logic [W-1:0] query_point_for(input int n);
		longint lo;
		longint hi;
		longint q;
		int     k;
		case ($urandom_range(9))
			0, 1, 2: q = bp_domain[$urandom_range(n - 1)];
			3, 4, 5, 6: begin
				if (n > 1) begin
					k = $urandom_range(n - 1, 1);
					lo = bp_domain[k-1];
					hi = bp_domain[k];
					q = lo + longint'(rand_below(hi - lo + 1));
				end else begin
					q = $signed(rand48());
				end
			end
			7: begin
				lo = bp_domain[0];
				q = (lo > FIELD_MIN) ? lo - 1 - longint'(rand_below(lo - FIELD_MIN)) : lo;
			end
			8: begin
				hi = bp_domain[n-1];
				q = (hi < FIELD_MAX) ? hi + 1 + longint'(rand_below(FIELD_MAX - hi)) : hi;
			end
			default: q = $signed(rand48());
		endcase
		return q[W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// receiver: random stalls, steady stretches, and one long hold-off
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold_cycles) @(posedge clk);
				sink_hold_cycles = 0;
				m_tready <= 1'b1;
			end else if (steady_flow) begin
				m_tready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin : result_check
		lookup_result_t want;
		logic [SEG_W-1:0] got_seg;
		if (arst_n && m_tvalid && m_tready) begin
			got_seg = m_tdata[OUT_SEG_LSB +: SEG_W];
			if (m_tuser < 5)
				status_seen[m_tuser]++;
			if (expected_lookups.size() == 0) begin
				error_count++;
				$error("result with nothing pending: value %h status %0d segment %0d",
					m_tdata[W-1:0], m_tuser, got_seg);
			end else begin
				want = expected_lookups.pop_front();
				if (m_tdata[W-1:0] !== want.value) begin
					error_count++;
					$error("result_value: expected %h actual %h", want.value, m_tdata[W-1:0]);
				end
				if (m_tuser !== want.status) begin
					error_count++;
					$error("status: expected %0d actual %0d", want.status, m_tuser);
				end
				if (got_seg !== want.seg) begin
					error_count++;
					$error("segment_index: expected %0d actual %0d", want.seg, got_seg);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("no progress after %0d cycles, %0d results still pending", CYCLE_LIMIT,
			expected_lookups.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// field extremes, every status, zero count and the top slot
	task automatic test_directed_cases();
		write_entry_count(6'd4);
		send_request(KIND_LOAD, 5'd0, W'(-64'sd65536000), W'(FIELD_MAX), '0);
		send_request(KIND_LOAD, 5'd1, '0, W'(FIELD_MIN), '0);
		send_request(KIND_LOAD, 5'd2, W'(64'sd327680), '0, '0);
		send_request(KIND_LOAD, 5'd3, W'(FIELD_MAX), W'(64'sd123), '1);
		// top slot, outside the active range
		send_request(KIND_LOAD, 5'd31, W'(FIELD_MIN), W'(FIELD_MAX), '1);
		// below first entry
		send_request(KIND_QUERY, '0, '0, '0, W'(FIELD_MIN));
		// exact hits and segments with the steepest falling and rising slopes
		send_request(KIND_QUERY, '1, '1, '1, W'(-64'sd65536000));
		send_request(KIND_QUERY, '0, '0, '0, W'(-64'sd32768000));
		send_request(KIND_QUERY, '0, '0, '0, '0);
		send_request(KIND_QUERY, '0, '0, '0, W'(64'sd327679));
		send_request(KIND_QUERY, '0, '0, '0, W'(FIELD_MAX - 1));
		send_request(KIND_QUERY, '0, '0, '0, W'(FIELD_MAX));
		// above last entry once the top one is out of range
		write_entry_count(6'd3);
		send_request(KIND_QUERY, '0, '0, '0, W'(64'sd400000));
		// a zero count still scans entry zero
		write_entry_count(6'd0);
		send_request(KIND_QUERY, '0, '0, '0, W'(-64'sd65536001));
		send_request(KIND_QUERY, '0, '0, '0, W'(-64'sd65536000));
		send_request(KIND_QUERY, '0, '0, '0, '0);
	endtask

	// receiver stops for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		int i;
		write_entry_count(6'd8);
		load_sorted_table(8);
		steady_flow = 1'b1;
		sink_hold_cycles = HOLD_CYCLES;
		for (i = 0; i < 12; i++)
			send_request(KIND_QUERY, IDX_W'($urandom), rand48(), rand48(), query_point_for(8));
		steady_flow = 1'b0;
	endtask

	// well-formed tables at many counts, each followed by a burst of queries
	task automatic test_sorted_tables();
		int               phase;
		int               i;
		int               n;
		logic [CNT_W-1:0] count;
		for (phase = 0; phase < 10; phase++) begin
			case (phase)
				0: count = 6'd32;
				1: count = 6'd63;
				2: count = 6'd1;
				3: count = 6'd0;
				4: count = 6'd33;
				5: count = 6'd17;
				6: count = 6'd2;
				default: count = CNT_W'($urandom_range(63));
			endcase
			write_entry_count(count);
			// one phase runs with no idling on either side
			steady_flow = (phase == 4);
			n = active_entries();
			load_sorted_table(n);
			for (i = 0; i < 35; i++)
				send_request(KIND_QUERY, IDX_W'($urandom), rand48(), rand48(),
					query_point_for(n));
		end
		steady_flow = 1'b0;
	endtask

	// unsorted and duplicate domains, loads and queries interleaved
	task automatic test_unsorted_noise();
		int           half;
		int           i;
		int           n;
		logic [W-1:0] d;
		write_entry_count(6'd32);
		for (i = 0; i < TABLE_DEPTH; i++) begin
			d = (i > 0 && $urandom_range(4) == 0) ? W'(bp_domain[$urandom_range(i - 1)]) :
				rand48();
			send_request(KIND_LOAD, IDX_W'(i), d, rand48(), rand48());
		end
		for (half = 0; half < 2; half++) begin
			if (half == 1)
				write_entry_count(CNT_W'($urandom_range(63)));
			n = active_entries();
			for (i = 0; i < 50; i++) begin
				if ($urandom_range(9) < 3) begin
					d = $urandom_range(1) ? rand48() :
						W'(bp_domain[$urandom_range(TABLE_DEPTH - 1)]);
					send_request(KIND_LOAD, IDX_W'($urandom), d, rand48(), rand48());
				end else begin
					d = $urandom_range(1) ? rand48() : W'(bp_domain[$urandom_range(n - 1)]);
					send_request(KIND_QUERY, IDX_W'($urandom), rand48(), rand48(), d);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= KIND_LOAD;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_output_backpressure();
		test_sorted_tables();
		test_unsorted_noise();

		// drain, then make sure nothing extra shows up
		wait_until_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d loads and %0d queries across %0d entry count settings",
			loads_sent, queries_sent, settings_used);
		$display("results seen: exact %0d, interpolated %0d, below %0d, above %0d, load %0d",
			status_seen[STAT_EXACT], status_seen[STAT_INTERP], status_seen[STAT_BELOW],
			status_seen[STAT_ABOVE], status_seen[STAT_LOAD]);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
